### rtl/core/mlfo_pkg.sv
// Shared types, constants and the quarter-wave sine table of the multi-waveform LFO.
package mlfo_pkg;

  localparam int PHASE_BITS  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int SCALE_BITS  = 16;
  localparam int NOISE_BITS  = 32;
  localparam int MUL_W       = 18;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int CFG_IDX_W   = 3;
  localparam int DRAW_CNT_W  = 5;

  localparam logic [NOISE_BITS-1:0] NOISE_SEED = 32'h1D87_2B41;
  localparam logic [NOISE_BITS-1:0] NOISE_TAPS = 32'h8020_0003;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_SYNC    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_TRI    = 3'd1;
  localparam logic [2:0] WAVE_SQUARE = 3'd2;
  localparam logic [2:0] WAVE_SAW    = 3'd3;
  localparam logic [2:0] WAVE_HOLD   = 3'd4;
  localparam logic [2:0] WAVE_SMOOTH = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_HIGH   = 3'd4;

  typedef struct packed {
    logic [1:0]            op;
    logic [PHASE_BITS-1:0] sync_phase;
  } lfo_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] wave_value;
    logic signed [SCALE_BITS-1:0]  scaled_value;
  } lfo_out_t;

  function automatic logic [15:0] sine_at(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd3212;
      5'd2:  v = 16'd6393;
      5'd3:  v = 16'd9512;
      5'd4:  v = 16'd12539;
      5'd5:  v = 16'd15446;
      5'd6:  v = 16'd18204;
      5'd7:  v = 16'd20787;
      5'd8:  v = 16'd23170;
      5'd9:  v = 16'd25329;
      5'd10: v = 16'd27245;
      5'd11: v = 16'd28898;
      5'd12: v = 16'd30273;
      5'd13: v = 16'd31356;
      5'd14: v = 16'd32137;
      5'd15: v = 16'd32609;
      default: v = 16'd32767;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/mlfo_lfsr.sv
// Galois noise register, advanced one shift per enabled cycle.
module mlfo_lfsr
  import mlfo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_i,
  output logic [NOISE_BITS-1:0] next_o
);

  logic [NOISE_BITS-1:0] noise_r;

  always_comb begin
    next_o = noise_r >> 1;
    if (noise_r[0]) begin
      next_o = next_o ^ NOISE_TAPS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r <= NOISE_SEED;
    end else if (step_i) begin
      noise_r <= next_o;
    end
  end

endmodule

### rtl/core/mlfo_mul.sv
// Shared signed multiplier with registered product.
module mlfo_mul
  import mlfo_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a_i * b_i;
  end

  assign prod_o = prod_r;

endmodule

### rtl/core/multiwave_lfo.sv
// Multi-waveform LFO top level: config registers, phase state, sequencer and datapath.
// Tick: the phase passes S_WAVE, S_SHAPE, S_SCALE and S_EMIT; the input stalls until S_IDLE.
// A tick that draws a random value first passes through S_DRAW (one noise shift per cycle).
// Restart runs three draws in S_DRAW (held, from, to); sync only loads the main phase.
// One registered multiplier serves sine interpolation, smooth random and scaling.
// Synchronous active-low reset clears phases and random values and reloads the noise seed.
module multiwave_lfo
  import mlfo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lfo_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lfo_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PHASE_BITS-1:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DRAW  = 6'b000010,
    S_WAVE  = 6'b000100,
    S_SHAPE = 6'b001000,
    S_SCALE = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  localparam logic [1:0] TGT_HELD = 2'd0;
  localparam logic [1:0] TGT_FROM = 2'd1;
  localparam logic [1:0] TGT_TO   = 2'd2;

  state_t state_r, state_nxt;

  logic [PHASE_BITS-1:0] phase_step_r, phase_offset_r;
  logic [2:0]            wave_sel_r;
  logic signed [SCALE_BITS-1:0] scale_low_r, scale_high_r;

  logic [PHASE_BITS-1:0] main_phase_r, main_phase_nxt;
  logic [PHASE_BITS-1:0] hold_phase_r, hold_phase_nxt;
  logic [PHASE_BITS-1:0] smooth_phase_r, smooth_phase_nxt;
  logic signed [SAMPLE_BITS-1:0] held_r, held_nxt;
  logic signed [SAMPLE_BITS-1:0] from_r, from_nxt;
  logic signed [SAMPLE_BITS-1:0] to_r, to_nxt;
  logic [1:0]            tgt_r, tgt_nxt;
  logic                  restart_r, restart_nxt;
  logic [DRAW_CNT_W-1:0] draw_cnt_r, draw_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [PHASE_BITS-1:0] p_r;
  logic [15:0]           base_r;
  logic                  neg_r;
  logic signed [SAMPLE_BITS-1:0] v_r, v_nxt;
  lfo_out_t              out_data_r;

  logic                  accept, out_free;
  logic [PHASE_BITS-1:0] main_off, main_adv;
  logic                  hold_c, smooth_c;
  logic [PHASE_BITS-1:0] hold_sum, smooth_sum;
  logic [NOISE_BITS-1:0] noise_next;
  logic signed [SAMPLE_BITS-1:0] drawn;

  logic [17:0] sx;
  logic [16:0] pos, pos17;
  logic [4:0]  idx;
  logic [15:0] base, diff;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [PROD_W-1:0] rnd_sum, smooth_adj;
  logic [15:0]       mag_m;
  logic signed [PROD_W-1:0] smooth_div;

  logic [PROD_W-1:0] sc_mag;
  logic [15:0]       q1, lo, q;
  logic [16:0]       r17, sq;
  logic signed [SCALE_BITS-1:0] scaled;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign main_off = main_phase_r + phase_offset_r;
  assign main_adv = main_phase_r + phase_step_r;
  assign {hold_c, hold_sum}     = {1'b0, hold_phase_r} + {1'b0, phase_step_r};
  assign {smooth_c, smooth_sum} = {1'b0, smooth_phase_r} + {1'b0, phase_step_r};

  mlfo_lfsr u_lfsr (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (state_r == S_DRAW),
    .next_o (noise_next)
  );

  assign drawn = noise_next[SAMPLE_BITS-1:0];

  // quarter-wave lookup for the sine
  always_comb begin
    sx    = p_r[PHASE_BITS-1 -: 18];
    pos   = {1'b0, sx[15:0]};
    pos17 = sx[16] ? (17'h10000 - pos) : pos;
    idx   = pos17[16:12];
    base  = sine_at(idx);
    diff  = sine_at(idx + 5'd1) - base;
  end

  always_comb begin
    mul_a = {2'b00, diff};
    mul_b = {6'd0, pos17[11:0]};
    if (state_r == S_WAVE && wave_sel_r == WAVE_SMOOTH) begin
      mul_a = {{2{to_r[SAMPLE_BITS-1]}}, to_r} - {{2{from_r[SAMPLE_BITS-1]}}, from_r};
      mul_b = {2'b00, smooth_phase_r[PHASE_BITS-1 -: 16]};
    end else if (state_r == S_SCALE || state_r == S_EMIT) begin
      mul_a = {2'b00, ~v_r[SAMPLE_BITS-1], v_r[SAMPLE_BITS-2:0]};
      mul_b = {{2{scale_high_r[SCALE_BITS-1]}}, scale_high_r}
            - {{2{scale_low_r[SCALE_BITS-1]}}, scale_low_r};
    end
  end

  mlfo_mul u_mul (
    .clk    (clk),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // wave shaping from the registered product and phase
  always_comb begin
    rnd_sum    = prod + PROD_W'(2048);
    mag_m      = base_r + rnd_sum[12 +: 16];
    smooth_adj = prod + (prod[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    smooth_div = $signed(smooth_adj) >>> 16;
    case (wave_sel_r)
      WAVE_SINE:   v_nxt = neg_r ? -$signed(mag_m) : $signed(mag_m);
      WAVE_TRI: begin
        if (!p_r[PHASE_BITS-1]) begin
          v_nxt = {~p_r[PHASE_BITS-2], p_r[PHASE_BITS-3 -: 15]};
        end else if (p_r[PHASE_BITS-2 -: 16] == 16'd0) begin
          v_nxt = 16'sh7FFF;
        end else begin
          v_nxt = 16'h8000 - p_r[PHASE_BITS-2 -: 16];
        end
      end
      WAVE_SQUARE: v_nxt = p_r[PHASE_BITS-1] ? 16'sh8000 : 16'sh7FFF;
      WAVE_SAW:    v_nxt = {~p_r[PHASE_BITS-1], p_r[PHASE_BITS-2 -: 15]};
      WAVE_HOLD:   v_nxt = held_r;
      WAVE_SMOOTH: v_nxt = from_r + smooth_div[SAMPLE_BITS-1:0];
      default:     v_nxt = '0;
    endcase
  end

  // divide by full range minus one, truncating toward zero
  always_comb begin
    sc_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    q1     = sc_mag[31:16];
    lo     = sc_mag[15:0];
    r17    = {1'b0, q1} + {1'b0, lo};
    q      = q1 + 16'(r17 >= 17'd65535);
    sq     = prod[PROD_W-1] ? (17'd0 - {1'b0, q}) : {1'b0, q};
    scaled = scale_low_r + sq[SCALE_BITS-1:0];
  end

  always_comb begin
    state_nxt        = state_r;
    main_phase_nxt   = main_phase_r;
    hold_phase_nxt   = hold_phase_r;
    smooth_phase_nxt = smooth_phase_r;
    held_nxt         = held_r;
    from_nxt         = from_r;
    to_nxt           = to_r;
    tgt_nxt          = tgt_r;
    restart_nxt      = restart_r;
    draw_cnt_nxt     = draw_cnt_r;
    out_valid_nxt    = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.op)
            OP_TICK: begin
              main_phase_nxt = main_adv;
              restart_nxt    = 1'b0;
              draw_cnt_nxt   = '0;
              state_nxt      = S_WAVE;
              if (wave_sel_r == WAVE_HOLD) begin
                hold_phase_nxt = hold_sum;
                if (hold_c) begin
                  tgt_nxt   = TGT_HELD;
                  state_nxt = S_DRAW;
                end
              end else if (wave_sel_r == WAVE_SMOOTH) begin
                smooth_phase_nxt = smooth_sum;
                if (smooth_c) begin
                  from_nxt  = to_r;
                  tgt_nxt   = TGT_TO;
                  state_nxt = S_DRAW;
                end
              end
            end
            OP_SYNC: main_phase_nxt = in_data.sync_phase;
            OP_RESTART: begin
              main_phase_nxt   = '0;
              hold_phase_nxt   = '0;
              smooth_phase_nxt = '0;
              restart_nxt      = 1'b1;
              tgt_nxt          = TGT_HELD;
              draw_cnt_nxt     = '0;
              state_nxt        = S_DRAW;
            end
            default: ;
          endcase
        end
      end
      S_DRAW: begin
        draw_cnt_nxt = draw_cnt_r + 1'b1;
        if (&draw_cnt_r) begin
          case (tgt_r)
            TGT_HELD: begin
              held_nxt  = drawn;
              tgt_nxt   = TGT_FROM;
              state_nxt = restart_r ? S_DRAW : S_WAVE;
            end
            TGT_FROM: begin
              from_nxt = drawn;
              tgt_nxt  = TGT_TO;
            end
            default: begin
              to_nxt    = drawn;
              state_nxt = restart_r ? S_IDLE : S_WAVE;
            end
          endcase
        end
      end
      S_WAVE:  state_nxt = S_SHAPE;
      S_SHAPE: state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      phase_step_r   <= '0;
      phase_offset_r <= '0;
      wave_sel_r     <= WAVE_SINE;
      scale_low_r    <= 16'sh8000;
      scale_high_r   <= 16'sh7FFF;
      main_phase_r   <= '0;
      hold_phase_r   <= '0;
      smooth_phase_r <= '0;
      held_r         <= '0;
      from_r         <= '0;
      to_r           <= '0;
      tgt_r          <= TGT_HELD;
      restart_r      <= 1'b0;
      draw_cnt_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      main_phase_r   <= main_phase_nxt;
      hold_phase_r   <= hold_phase_nxt;
      smooth_phase_r <= smooth_phase_nxt;
      held_r         <= held_nxt;
      from_r         <= from_nxt;
      to_r           <= to_nxt;
      tgt_r          <= tgt_nxt;
      restart_r      <= restart_nxt;
      draw_cnt_r     <= draw_cnt_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PHASE_STEP:   phase_step_r   <= cfg_data;
          CFG_PHASE_OFFSET: phase_offset_r <= cfg_data;
          CFG_WAVE_SELECT:  wave_sel_r     <= cfg_data[2:0];
          CFG_SCALE_LOW:    scale_low_r    <= cfg_data[SCALE_BITS-1:0];
          CFG_SCALE_HIGH:   scale_high_r   <= cfg_data[SCALE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      p_r <= main_off;
    end
    if (state_r == S_WAVE) begin
      base_r <= base;
      neg_r  <= sx[17];
    end
    if (state_r == S_SHAPE) begin
      v_r <= v_nxt;
    end
    if (state_r == S_EMIT && out_free) begin
      out_data_r.wave_value   <= v_r;
      out_data_r.scaled_value <= scaled;
    end
  end

endmodule

### rtl/core/mlfo_chk.sv
// Port-level checker for the multi-waveform LFO, bound to the top level.
module mlfo_chk
  import mlfo_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input lfo_in_t               in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input lfo_out_t              out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.op == OP_TICK || in_data.op == OP_RESTART)
    |=> in_stall)
    else $error("input not stalled after a tick or restart beat");

  a_sync_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.op == OP_SYNC && !out_valid |=> !out_valid)
    else $error("sync beat produced a result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind multiwave_lfo mlfo_chk u_mlfo_chk (.*);

### verif/tb_multiwave_lfo.sv
// Self-checking testbench for multiwave_lfo: directed table, random phases, golden predictor.
module tb_multiwave_lfo;
  timeunit 1ns;
  timeprecision 1ps;
  import mlfo_pkg::*;

  localparam int          SETTLE_CYCLES = 140;
  localparam logic [31:0] LFSR_SEED     = 32'h1D87_2B41;
  localparam logic [31:0] LFSR_TAPS     = 32'h8020_0003;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          cdata;
    lfo_in_t              item;
    bit                   lit;
    lfo_out_t             want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  lfo_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  lfo_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [PHASE_BITS-1:0] cfg_data;

  // predictor copy of registers and state
  logic [31:0]        p_step, p_offset;
  logic [2:0]         wsel;
  logic signed [15:0] scale_lo, scale_hi;
  logic [31:0]        main_ph, hold_ph, smooth_ph;
  logic signed [15:0] held_rnd, rnd_from, rnd_to;
  logic [31:0]        lfsr;

  lfo_out_t sample_q[$];
  lfo_out_t mon_want;
  int       mismatch_cnt = 0;
  int       in_gap_max = 16;
  int       out_stall_max = 16;
  int       stall_left = 0;
  bit       stall_redraw = 1'b1;
  row_t     dir_rows[$];

  multiwave_lfo u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int quarter_pt(int i);
    case (i)
      0:  return 0;
      1:  return 3212;
      2:  return 6393;
      3:  return 9512;
      4:  return 12539;
      5:  return 15446;
      6:  return 18204;
      7:  return 20787;
      8:  return 23170;
      9:  return 25329;
      10: return 27245;
      11: return 28898;
      12: return 30273;
      13: return 31356;
      14: return 32137;
      15: return 32609;
      default: return 32767;
    endcase
  endfunction

  function automatic int sine_of(logic [31:0] p);
    logic [1:0] quad;
    int pos, idx, frac, m;
    quad = p[31:30];
    pos = p[29:14];
    if (quad[0]) pos = 65536 - pos;
    idx = pos >> 12;
    frac = pos & 4095;
    if (idx >= 16) m = 32767;
    else m = quarter_pt(idx) + (((quarter_pt(idx + 1) - quarter_pt(idx)) * frac + 2048) >> 12);
    return quad[1] ? -m : m;
  endfunction

  function automatic int triangle_of(logic [31:0] p);
    int t, v;
    t = p[31:15];
    if (t < 65536) return t - 32768;
    v = 32768 - (t - 65536);
    return (v > 32767) ? 32767 : v;
  endfunction

  function automatic logic signed [15:0] noise_draw();
    for (int k = 0; k < 32; k++)
      lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
    return lfsr[15:0];
  endfunction

  function automatic bit acc_advance(inout logic [31:0] acc);
    logic carry;
    {carry, acc} = {1'b0, acc} + {1'b0, p_step};
    return carry;
  endfunction

  function automatic bit lfo_predict(input lfo_in_t it, output lfo_out_t res);
    logic [31:0] p;
    longint v, sc;
    int t;
    res = '0;
    case (it.op)
      OP_TICK: ;
      OP_SYNC: begin
        main_ph = it.sync_phase;
        return 1'b0;
      end
      OP_RESTART: begin
        main_ph = '0;
        hold_ph = '0;
        smooth_ph = '0;
        held_rnd = noise_draw();
        rnd_from = noise_draw();
        rnd_to = noise_draw();
        return 1'b0;
      end
      default: return 1'b0;
    endcase
    p = main_ph + p_offset;
    case (wsel)
      WAVE_SINE:   v = sine_of(p);
      WAVE_TRI:    v = triangle_of(p);
      WAVE_SQUARE: v = p[31] ? -32768 : 32767;
      WAVE_SAW: begin
        t = p[31:16];
        v = t - 32768;
      end
      WAVE_HOLD: begin
        if (acc_advance(hold_ph)) held_rnd = noise_draw();
        v = held_rnd;
      end
      WAVE_SMOOTH: begin
        if (acc_advance(smooth_ph)) begin
          rnd_from = rnd_to;
          rnd_to = noise_draw();
        end
        v = rnd_from + ((longint'(rnd_to) - rnd_from) * longint'(smooth_ph[31:16])) / 65536;
      end
      default: v = 0;
    endcase
    void'(acc_advance(main_ph));
    sc = scale_lo + ((v + 32768) * (longint'(scale_hi) - scale_lo)) / 65535;
    res.wave_value = v[15:0];
    res.scaled_value = sc[15:0];
    return 1'b1;
  endfunction

  function automatic void cfg_apply(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    case (idx)
      CFG_PHASE_STEP:   p_step = d;
      CFG_PHASE_OFFSET: p_offset = d;
      CFG_WAVE_SELECT:  wsel = d[2:0];
      CFG_SCALE_LOW:    scale_lo = d[15:0];
      CFG_SCALE_HIGH:   scale_hi = d[15:0];
      default: ;
    endcase
  endfunction

  function automatic row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.cdata = d;
    return r;
  endfunction

  function automatic row_t row_item(logic [1:0] op, logic [31:0] ph);
    row_t r;
    r = '{default: '0};
    r.item.op = op;
    r.item.sync_phase = ph;
    return r;
  endfunction

  function automatic row_t row_lit(int w, int s);
    row_t r;
    r = row_item(OP_TICK, $urandom());
    r.lit = 1'b1;
    r.want.wave_value = 16'(w);
    r.want.scaled_value = 16'(s);
    return r;
  endfunction

  function automatic logic [31:0] pick_scale();
    logic [31:0] d;
    d = $urandom();
    case ($urandom_range(0, 4))
      0: d[15:0] = 16'h8000;
      1: d[15:0] = 16'h7FFF;
      2: d[15:0] = 16'h0000;
      default: ;
    endcase
    return d;
  endfunction

  task automatic send_item(input lfo_in_t it, input bit lit, input lfo_out_t want);
    lfo_out_t res;
    int gap;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (lfo_predict(it, res)) sample_q.push_back(lit ? want : res);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_apply(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_redraw) begin
      stall_left = $urandom_range(0, out_stall_max);
      stall_redraw = 1'b0;
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      stall_redraw = 1'b1;
      if (sample_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected beat: wave %0d scaled %0d", $time,
                 out_data.wave_value, out_data.scaled_value);
      end else begin
        mon_want = sample_q.pop_front();
        if (out_data.wave_value !== mon_want.wave_value) begin
          mismatch_cnt++;
          $display("%0t: wave_value expected %0d actual %0d", $time,
                   mon_want.wave_value, out_data.wave_value);
        end
        if (out_data.scaled_value !== mon_want.scaled_value) begin
          mismatch_cnt++;
          $display("%0t: scaled_value expected %0d actual %0d", $time,
                   mon_want.scaled_value, out_data.scaled_value);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    lfo_in_t     it;
    logic [31:0] d;
    int          wave;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    p_step = '0;
    p_offset = '0;
    wsel = WAVE_SINE;
    scale_lo = 16'sh8000;
    scale_hi = 16'sh7FFF;
    main_ph = '0;
    hold_ph = '0;
    smooth_ph = '0;
    held_rnd = '0;
    rnd_from = '0;
    rnd_to = '0;
    lfsr = LFSR_SEED;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    dir_rows.push_back(row_lit(0, 0));
    dir_rows.push_back(row_cfg(CFG_WAVE_SELECT, {29'd0, WAVE_SQUARE}));
    dir_rows.push_back(row_lit(32767, 32767));
    dir_rows.push_back(row_item(OP_SYNC, 32'h8000_0000));
    dir_rows.push_back(row_lit(-32768, -32768));
    dir_rows.push_back(row_cfg(CFG_WAVE_SELECT, {29'd0, WAVE_SAW}));
    dir_rows.push_back(row_item(OP_SYNC, 32'hFFFF_FFFF));
    dir_rows.push_back(row_lit(32767, 32767));
    dir_rows.push_back(row_cfg(CFG_WAVE_SELECT, {29'd0, WAVE_TRI}));
    dir_rows.push_back(row_item(OP_SYNC, 32'h0000_0000));
    dir_rows.push_back(row_lit(-32768, -32768));
    dir_rows.push_back(row_cfg(CFG_WAVE_SELECT, 32'd6));
    dir_rows.push_back(row_lit(0, 0));
    dir_rows.push_back(row_cfg(CFG_WAVE_SELECT, 32'hFFFF_FFFF));
    dir_rows.push_back(row_lit(0, 0));
    dir_rows.push_back(row_cfg(CFG_SCALE_LOW, 32'h0000_7FFF));
    dir_rows.push_back(row_cfg(CFG_SCALE_HIGH, 32'hFFFF_8000));
    dir_rows.push_back(row_cfg(CFG_WAVE_SELECT, {29'd0, WAVE_SQUARE}));
    dir_rows.push_back(row_item(OP_SYNC, 32'h0000_0000));
    dir_rows.push_back(row_lit(32767, -32768));
    dir_rows.push_back(row_item(2'd3, 32'hA5A5_5A5A));
    dir_rows.push_back(row_cfg(CFG_PHASE_STEP, 32'h1234_5678));
    dir_rows.push_back(row_cfg(CFG_PHASE_OFFSET, 32'hC000_0000));
    dir_rows.push_back(row_cfg(CFG_WAVE_SELECT, {29'd0, WAVE_SINE}));
    dir_rows.push_back(row_cfg(3'd5, 32'h5A5A_A5A5));
    repeat (4) dir_rows.push_back(row_item(OP_TICK, 32'h0F0F_F0F0));
    dir_rows.push_back(row_item(OP_RESTART, 32'h3C3C_C3C3));
    dir_rows.push_back(row_cfg(CFG_WAVE_SELECT, {29'd0, WAVE_HOLD}));
    dir_rows.push_back(row_cfg(CFG_PHASE_STEP, 32'h9000_0000));
    repeat (3) dir_rows.push_back(row_item(OP_TICK, 32'h0000_0000));
    dir_rows.push_back(row_cfg(CFG_WAVE_SELECT, {29'd0, WAVE_SMOOTH}));
    repeat (3) dir_rows.push_back(row_item(OP_TICK, 32'hFFFF_FFFF));
    dir_rows.push_back(row_item(OP_RESTART, 32'h0000_0000));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) cfg_write(dir_rows[i].idx, dir_rows[i].cdata);
      else send_item(dir_rows[i].item, dir_rows[i].lit, dir_rows[i].want);
    end

    for (int ph = 0; ph < 12; ph++) begin
      in_gap_max = (ph % 3 == 1) ? 0 : 16;
      out_stall_max = (ph % 4 == 2) ? 0 : 16;
      wave = (ph < 8) ? ph : $urandom_range(WAVE_HOLD, 7);
      d = $urandom();
      d[2:0] = wave[2:0];
      cfg_write(CFG_WAVE_SELECT, d);
      case ($urandom_range(0, 5))
        0: d = 32'h0000_0000;
        1: d = 32'hFFFF_FFFF;
        2: d = 32'h8000_0000;
        3: d = $urandom();
        default: d = $urandom() >> $urandom_range(2, 28);
      endcase
      cfg_write(CFG_PHASE_STEP, d);
      d = $urandom();
      if ($urandom_range(0, 3) == 0) d = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      cfg_write(CFG_PHASE_OFFSET, d);
      cfg_write(CFG_SCALE_LOW, pick_scale());
      cfg_write(CFG_SCALE_HIGH, pick_scale());
      if ($urandom_range(0, 2) == 0) cfg_write(3'($urandom_range(5, 7)), $urandom());
      for (int k = 0; k < 92; k++) begin
        it.sync_phase = $urandom();
        case ($urandom_range(0, 99)) inside
          [0:81]:  it.op = OP_TICK;
          [82:89]: it.op = OP_SYNC;
          [90:95]: it.op = OP_RESTART;
          default: it.op = 2'd3;
        endcase
        if (it.op == OP_SYNC && $urandom_range(0, 4) == 0)
          it.sync_phase = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
        send_item(it, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
